[design/median_3x3_filter_assert.svh]
`ifndef MEDIAN_3X3_FILTER_ASSERT_SVH
`define MEDIAN_3X3_FILTER_ASSERT_SVH

// Checks that a condition implies another one at the same clock edge.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another one at the following clock edge.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mf3_pkg.sv]
package mf3_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned ROW_W = 12;
  localparam int unsigned COL_W = 10;
  localparam int unsigned CFG_W = 12;
  localparam int unsigned WIDTH_REG_W = 11;

  localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = 11'd640;
  localparam logic [ROW_W-1:0] IMAGE_HEIGHT_RESET = 12'd480;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } mf3_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } mf3_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             frame_end;
  } mf3_out_t;

  // Position data that rides along with a window through the pipeline.
  typedef struct packed {
    logic             res_valid;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             frame_end;
  } mf3_meta_t;

endpackage

[design/mf3_window.sv]
module mf3_window
  import mf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           acc_i,
  input  logic [PIX_W-1:0]               px_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   addr_i,
  input  mf3_meta_t                      meta_i,
  output logic [8:0][PIX_W-1:0]          win_o,
  output mf3_meta_t                      meta_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] rd_up_q, rd_mid_q;
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [AW-1:0]    s1_addr_q;
  mf3_meta_t        s1_meta_q;

  logic             lw_valid_q;
  logic [AW-1:0]    lw_addr_q;
  logic [PIX_W-1:0] lw_up_q, lw_mid_q;

  logic [5:0][PIX_W-1:0] col_q;

  logic             hit;
  logic [PIX_W-1:0] up, mid;
  logic             wr_en;

  // A read issued in the same cycle as the write to the same column sees the
  // old data, so the last write is kept and forwarded.
  assign hit   = lw_valid_q && (lw_addr_q == s1_addr_q);
  assign up    = hit ? lw_up_q : rd_up_q;
  assign mid   = hit ? lw_mid_q : rd_mid_q;
  assign wr_en = en_i && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      rd_up_q  <= upper_mem[addr_i];
      rd_mid_q <= middle_mem[addr_i];
    end
    if (wr_en) begin
      upper_mem[s1_addr_q]  <= mid;
      middle_mem[s1_addr_q] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_px_q   <= px_i;
      s1_addr_q <= addr_i;
      s1_meta_q <= meta_i;
    end
    if (wr_en) begin
      lw_addr_q <= s1_addr_q;
      lw_up_q   <= mid;
      lw_mid_q  <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
      col_q      <= '0;
    end else begin
      if (en_i) begin
        s1_valid_q <= acc_i;
      end
      if (wr_en) begin
        lw_valid_q <= 1'b1;
        col_q[0]   <= col_q[1];
        col_q[1]   <= up;
        col_q[2]   <= col_q[3];
        col_q[3]   <= mid;
        col_q[4]   <= col_q[5];
        col_q[5]   <= s1_px_q;
      end
    end
  end

  assign win_o[0] = col_q[0];
  assign win_o[1] = col_q[1];
  assign win_o[2] = up;
  assign win_o[3] = col_q[2];
  assign win_o[4] = col_q[3];
  assign win_o[5] = mid;
  assign win_o[6] = col_q[4];
  assign win_o[7] = col_q[5];
  assign win_o[8] = s1_px_q;

  always_comb begin
    meta_o           = s1_meta_q;
    meta_o.res_valid = s1_valid_q && s1_meta_q.res_valid;
  end

endmodule

[design/mf3_max_cell.sv]
module mf3_max_cell
  import mf3_pkg::*;
#(
  parameter int unsigned N = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [N-1:0][PIX_W-1:0] vals_i,
  input  mf3_meta_t             meta_i,
  output logic [N-1:0][PIX_W-1:0] vals_o,
  output mf3_meta_t             meta_o
);

  localparam int unsigned IW = $clog2(N);

  logic [IW-1:0]              best;
  logic [N-1:0][PIX_W-1:0]    swapped;
  logic [N-1:0][PIX_W-1:0]    vals_q;
  mf3_meta_t                  meta_q;

  // The largest value moves to the top slot; the next cell works on the rest.
  always_comb begin
    best = '0;
    for (int k = 1; k < N; k++) begin
      if (vals_i[k] >= vals_i[best]) begin
        best = IW'(k);
      end
    end
    swapped       = vals_i;
    swapped[N-1]  = vals_i[best];
    swapped[best] = vals_i[N-1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vals_q <= swapped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q <= meta_i;
    end
  end

  assign vals_o = vals_q;
  assign meta_o = meta_q;

endmodule

[design/median_3x3_filter.sv]
// A result passes the window stage, the five max-extraction cells and out_q to out_valid_o.
// One pixel per cycle unless the input is stalled; each max-extraction cell is registered.
// Input stalls only while the output skid register is occupied.
// Reset clears counters, window, pipeline valids and restores 640x480.
// The line stores are not cleared; they fill during the first two rows of a frame.
`include "median_3x3_filter_assert.svh"

module median_3x3_filter
  import mf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  mf3_in_t          in_data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output mf3_out_t         out_data_o,
  input  logic             out_stall_i,
  input  logic             cfg_we_i,
  input  mf3_reg_e         cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WEW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (WEW > WIDTH_REG_W) ? WEW : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0] width_q;
  logic [ROW_W-1:0]       height_q;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [CW-1:0]          col_q, col_d;

  logic [CMPW-1:0]  width_ext;
  logic [WEW-1:0]   w_eff;
  logic [ROW_W-1:0] h_eff;

  logic             en, acc;
  logic [ROW_W-1:0] row_cur, row_inc;
  logic [CW-1:0]    col_cur;
  logic [WEW-1:0]   col_ext, col_inc;
  mf3_meta_t        meta_in;

  logic [8:0][PIX_W-1:0] win;
  mf3_meta_t             win_meta;
  logic [8:0][PIX_W-1:0] c0_vals;
  logic [7:0][PIX_W-1:0] c1_vals;
  logic [6:0][PIX_W-1:0] c2_vals;
  logic [5:0][PIX_W-1:0] c3_vals;
  logic [4:0][PIX_W-1:0] c4_vals;
  mf3_meta_t             c0_meta, c1_meta, c2_meta, c3_meta, c4_meta;

  mf3_out_t res;
  logic     res_take;
  logic     out_valid_q, skid_valid_q;
  mf3_out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_WIDTH_RESET;
      height_q <= IMAGE_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    width_ext = CMPW'(width_q);
    if (width_ext < CMPW'(3)) begin
      w_eff = WEW'(3);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_ext);
    end
    h_eff = (height_q < 12'd3) ? 12'd3 : height_q;
  end

  assign en         = !skid_valid_q;
  assign acc        = in_valid_i && en;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    row_cur = in_data_i.frame_start ? '0 : row_q;
    col_cur = in_data_i.frame_start ? '0 : col_q;
    col_ext = WEW'(col_cur);
    col_inc = col_ext + WEW'(1);
    row_inc = row_cur + 12'd1;

    meta_in.res_valid  = (row_cur >= 12'd2) && (col_cur >= CW'(2)) &&
                         (row_cur < h_eff) && (col_ext < w_eff);
    meta_in.center_row = row_cur - 12'd1;
    meta_in.center_col = COL_W'(col_cur - CW'(1));
    meta_in.frame_end  = (row_cur == h_eff - 12'd1) && (col_ext == w_eff - WEW'(1));

    // Counters wrap at the effective limits, so pixels past the frame end
    // start the next frame.
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc;
    end else begin
      col_d = CW'(col_inc);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  mf3_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .acc_i  (acc),
    .px_i   (in_data_i.pixel),
    .addr_i (col_cur),
    .meta_i (meta_in),
    .win_o  (win),
    .meta_o (win_meta)
  );

  mf3_max_cell #(.N(9)) u_cell0 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vals_i(win), .meta_i(win_meta), .vals_o(c0_vals), .meta_o(c0_meta)
  );

  mf3_max_cell #(.N(8)) u_cell1 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vals_i(c0_vals[7:0]), .meta_i(c0_meta), .vals_o(c1_vals), .meta_o(c1_meta)
  );

  mf3_max_cell #(.N(7)) u_cell2 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vals_i(c1_vals[6:0]), .meta_i(c1_meta), .vals_o(c2_vals), .meta_o(c2_meta)
  );

  mf3_max_cell #(.N(6)) u_cell3 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vals_i(c2_vals[5:0]), .meta_i(c2_meta), .vals_o(c3_vals), .meta_o(c3_meta)
  );

  mf3_max_cell #(.N(5)) u_cell4 (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vals_i(c3_vals[4:0]), .meta_i(c3_meta), .vals_o(c4_vals), .meta_o(c4_meta)
  );

  // After four maxima are removed, the largest of the last five is the median.
  assign res.median     = c4_vals[4];
  assign res.center_row = c4_meta.center_row;
  assign res.center_col = c4_meta.center_col;
  assign res.frame_end  = c4_meta.frame_end;
  assign res_take       = en && c4_meta.res_valid;

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else begin
        out_q <= res;
      end
    end else if (res_take) begin
      skid_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q  <= skid_valid_q || res_take;
      skid_valid_q <= 1'b0;
    end else if (res_take) begin
      skid_valid_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MF3_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full while output empty")
  `MF3_ASSERT_NOW(a_skid_fill, $rose(skid_valid_q), $past(out_valid_q && out_stall_i), "skid filled without a held beat")
  `MF3_ASSERT_NEXT(a_skid_drain, skid_valid_q && !out_stall_i, !skid_valid_q, "skid did not drain")
  `MF3_ASSERT_NOW(a_frame_end_pos, out_valid_q && out_q.frame_end, out_q.center_row == h_eff - 12'd2, "frame end beat at wrong row")
  `MF3_ASSERT_NOW(a_interior, out_valid_q, (out_q.center_row != 12'd0) && (out_q.center_col != 10'd0), "border position in result")

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mf3_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned RANDOM_ITEMS = 630;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef enum int unsigned {
    PIX_ANY,
    PIX_RAILS,
    PIX_STEPS
  } pixel_mix_e;

  // Tracks the filter's counters, line stores and window, and keeps the medians
  // still owed by the block in arrival order.
  class median_tracker;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    logic [PIX_W-1:0]       upper_row [MAX_W];
    logic [PIX_W-1:0]       middle_row [MAX_W];
    bit                     upper_known [MAX_W];
    bit                     middle_known [MAX_W];
    logic [PIX_W-1:0]       win [6];
    int unsigned            row_cnt;
    int unsigned            col_cnt;
    mf3_out_t               medians_due [$];
    int unsigned            errors;

    function new();
      width_reg  = IMAGE_WIDTH_RESET;
      height_reg = IMAGE_HEIGHT_RESET;
      for (int c = 0; c < MAX_W; c++) begin
        upper_row[c]  = '0;
        middle_row[c] = '0;
      end
      for (int k = 0; k < 6; k++) win[k] = '0;
      row_cnt = 0;
      col_cnt = 0;
      errors  = 0;
    endfunction

    function int unsigned clamp_width(logic [WIDTH_REG_W-1:0] w);
      if (w < 3) return 3;
      if (w > MAX_W) return MAX_W;
      return 32'(w);
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function int unsigned frame_pixels();
      return clamp_width(width_reg) * eff_height();
    endfunction

    function int unsigned pending();
      return medians_due.size();
    endfunction

    // True when every column below the given width holds written data in both
    // line stores, so that no median can pick up an uninitialized sample.
    function bit stores_ready(logic [CFG_W-1:0] wval);
      int unsigned w;
      w = clamp_width(wval[WIDTH_REG_W-1:0]);
      for (int unsigned c = 0; c < w; c++)
        if (!(upper_known[c] && middle_known[c])) return 1'b0;
      return 1'b1;
    endfunction

    function void set_reg(mf3_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = val[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] middle_of_nine(logic [PIX_W-1:0] v [9]);
      logic [PIX_W-1:0] s [9];
      logic [PIX_W-1:0] t;
      int j;
      s = v;
      for (int i = 1; i < 9; i++) begin
        t = s[i];
        j = i;
        while (j > 0 && s[j-1] > t) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = t;
      end
      return s[4];
    endfunction

    function void take_pixel(mf3_in_t beat);
      int unsigned w;
      int unsigned h;
      int unsigned ci;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] v [9];
      mf3_out_t r;
      w = clamp_width(width_reg);
      h = eff_height();
      if (beat.frame_start) begin
        row_cnt = 0;
        col_cnt = 0;
      end
      ci  = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
      up  = upper_row[ci];
      mid = middle_row[ci];
      if (row_cnt >= 2 && col_cnt >= 2 && row_cnt < h && col_cnt < w) begin
        v = '{win[0], win[1], up, win[2], win[3], mid, win[4], win[5], beat.pixel};
        r.median     = middle_of_nine(v);
        r.center_row = ROW_W'(row_cnt - 1);
        r.center_col = COL_W'(col_cnt - 1);
        r.frame_end  = (row_cnt == h - 1) && (col_cnt == w - 1);
        medians_due.push_back(r);
      end
      upper_known[ci]  = middle_known[ci];
      middle_known[ci] = 1'b1;
      upper_row[ci]    = mid;
      middle_row[ci]   = beat.pixel;
      win[0] = win[1];
      win[1] = up;
      win[2] = win[3];
      win[3] = mid;
      win[4] = win[5];
      win[5] = beat.pixel;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void check_median(mf3_out_t got);
      mf3_out_t want;
      if (medians_due.size() == 0) begin
        $error("unexpected result: median %0d row %0d col %0d frame_end %0b",
               got.median, got.center_row, got.center_col, got.frame_end);
        errors++;
        return;
      end
      want = medians_due.pop_front();
      if (got.median !== want.median) begin
        $error("median: expected %0d, got %0d", want.median, got.median);
        errors++;
      end
      if (got.center_row !== want.center_row) begin
        $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
        errors++;
      end
      if (got.center_col !== want.center_col) begin
        $error("center_col: expected %0d, got %0d", want.center_col, got.center_col);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i;
  mf3_in_t          in_data_i;
  logic             in_stall_o;
  logic             out_valid_o;
  mf3_out_t         out_data_o;
  logic             out_stall_i;
  logic             cfg_we_i;
  mf3_reg_e         cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  median_tracker tracker = new();
  int unsigned   in_idle_pct = 21;
  int unsigned   out_stall_pct = 48;
  int unsigned   pixels_sent = 0;
  int unsigned   quiet_cycles = 0;

  median_3x3_filter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_IMAGE_WIDTH;
    cfg_data_i  <= '0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Result check and watchdog; the watchdog restarts on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_median(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [PIX_W-1:0] random_pixel(pixel_mix_e mix);
    case (mix)
      PIX_ANY:   return PIX_W'($urandom_range(255));
      PIX_RAILS: begin
        case ($urandom_range(2))
          0:       return 8'h00;
          1:       return 8'hFF;
          default: return PIX_W'($urandom_range(255));
        endcase
      end
      default:   return PIX_W'($urandom_range(3) * 85);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    logic [CFG_W-1:0] v;
    v = CFG_W'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12));
    // The top data bit lies outside the width register and must be ignored.
    if ($urandom_range(3) == 0) v[CFG_W-1] = 1'b1;
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    return CFG_W'(($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 9));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    mf3_in_t beat;
    beat.pixel       = pix;
    beat.frame_start = fs;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_pixel(beat);
    pixels_sent++;
  endtask

  task automatic send_run(input int unsigned count, input bit lead, input bit noisy,
                          input pixel_mix_e mix);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(random_pixel(mix), (i == 0 && lead) || (noisy && $urandom_range(99) < 4));
  endtask

  // Stops the pixel stream until every owed median is back, then lets the
  // pipeline settle so a register write cannot catch a beat in flight.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_IMAGE_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    tracker.set_reg(REG_IMAGE_WIDTH, w);
    cfg_idx_i  <= REG_IMAGE_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    tracker.set_reg(REG_IMAGE_HEIGHT, h);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned rand_base;
    int unsigned pick;
    bit first;
    logic [CFG_W-1:0] w;
    pixel_mix_e mix;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Undersized registers clamp to a 3x3 frame with a single interior pixel.
    set_geometry(12'd2, 12'd0);
    for (int i = 0; i < 9; i++) send_pixel(8'hFF, i == 0);
    // No frame start here: the counters must wrap on their own.
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h07, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h00, 1'b0);
    // A frame start in the middle of a frame.
    send_pixel(8'h12, 1'b0);
    send_pixel(8'h34, 1'b0);
    send_pixel(8'h56, 1'b1);
    send_pixel(8'h78, 1'b0);
    send_pixel(8'h9A, 1'b0);

    // Tallest frame, only its first rows.
    drain_results();
    set_geometry(12'h800, 12'hFFF);
    send_run(15, 1'b1, 1'b0, PIX_ANY);

    // Oversized width clamps to the full line length. Shrinking the width
    // afterwards yields a median whose position shows where the row wrapped.
    drain_results();
    set_geometry(12'h7FF, 12'd2);
    send_run(MAX_W + 6, 1'b1, 1'b0, PIX_ANY);
    drain_results();
    set_geometry(12'd3, 12'd2);
    send_run(4, 1'b0, 1'b0, PIX_ANY);

    rand_base = pixels_sent;
    first = 1'b1;
    while (pixels_sent - rand_base < RANDOM_ITEMS) begin
      if (pixels_sent - rand_base < RANDOM_ITEMS / 3) begin
        in_idle_pct   = 21;
        out_stall_pct = 48;
      end else if (pixels_sent - rand_base < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct   = 48;
        out_stall_pct = 21;
      end else begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
      end
      pick = $urandom_range(99);
      mix  = pixel_mix_e'($urandom_range(2));
      if (first || pick < 12) begin
        drain_results();
        set_geometry(pick_width(), pick_height());
        send_run(tracker.frame_pixels(), 1'b1, 1'b0, mix);
      end else if (pick < 20) begin
        // Change the geometry partway through a frame.
        send_run($urandom_range(1, tracker.frame_pixels() - 1), 1'($urandom_range(1)),
                 1'b0, mix);
        drain_results();
        w = pick_width();
        if (!tracker.stores_ready(w)) w = CFG_W'(tracker.width_reg);
        set_geometry(w, pick_height());
      end else if (pick < 28) begin
        send_run($urandom_range(1, tracker.frame_pixels()), 1'($urandom_range(1)), 1'b1, mix);
      end else begin
        send_run(tracker.frame_pixels(), $urandom_range(99) < 90, 1'b0, mix);
      end
      first = 1'b0;
    end

    drain_results();
    if (tracker.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
